/* hw/rtl/mtlf_pkg.sv */
// meteor trail frame package: shared types, constants and register indexes
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package mtlf_pkg;

  localparam int MASK_W = 64;
  localparam int IDX_W  = 6;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int LEN_W  = 7;

  localparam logic [HUE_W-1:0] METEOR_HUE = 9'd240;
  localparam logic [PCT_W-1:0] METEOR_SAT = 7'd60;
  localparam logic [PCT_W-1:0] MAX_PCT    = 7'd100;

  localparam logic [PCT_W-1:0] RST_INTENSITY = 7'd100;
  localparam logic [PCT_W-1:0] RST_FADE_STEP = 7'd10;
  localparam logic [LEN_W-1:0] RST_LENGTH    = 7'd8;

  typedef enum logic [1:0] {
    REG_ENABLED,
    REG_METEOR_INTENSITY,
    REG_FADE_STEP,
    REG_METEOR_LENGTH
  } reg_idx_t;

  typedef struct packed {
    logic             enabled;
    logic [PCT_W-1:0] meteor_intensity;
    logic [PCT_W-1:0] fade_step;
    logic [LEN_W-1:0] meteor_length;
  } cfg_t;

  // one stored pixel: lit means hue and saturation of the meteor
  typedef struct packed {
    logic             lit;
    logic [PCT_W-1:0] intensity;
  } pix_t;

  typedef struct packed {
    logic             start;
    logic             issue;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic can_adv;
    logic s2_valid;
  } sts_t;

endpackage

/* hw/rtl/mtlf_frame_if.sv */
// frame tick channel: valid, ready and the fade mask word
// depends on mtlf_pkg
interface mtlf_frame_if;
  import mtlf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fade_mask;

  modport source (output valid, output fade_mask, input ready);
  modport sink (input valid, input fade_mask, output ready);
endinterface

/* hw/rtl/mtlf_pixel_if.sv */
// pixel channel: valid, ready and one pixel word
// depends on mtlf_pkg
interface mtlf_pixel_if;
  import mtlf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] intensity;
  logic             last_pixel;

  modport source (
    output valid, output pixel_index, output hue, output saturation,
    output intensity, output last_pixel, input ready
  );
  modport sink (
    input valid, input pixel_index, input hue, input saturation,
    input intensity, input last_pixel, output ready
  );
endinterface

/* hw/rtl/mtlf_ctrl.sv */
// meteor trail controller: accepts frame ticks and sequences the pixel sweep
// depends on mtlf_pkg
module mtlf_ctrl #(
  parameter int STRIP_LENGTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          enabled,
  input  mtlf_pkg::sts_t sts,
  output mtlf_pkg::cmd_t cmd
);
  import mtlf_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FLUSH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic             cnt_last;

  always_comb begin
    in_ready  = (state == IDLE);
    cnt_last  = (cnt == IDX_W'(STRIP_LENGTH - 1));
    cmd.start = in_valid && in_ready && enabled;
    cmd.issue = (state == RUN) && sts.can_adv;
    cmd.idx   = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.start) begin
            state <= RUN;
            cnt   <= '0;
          end
        end
        RUN: begin
          if (cmd.issue) begin
            if (cnt_last) begin
              state <= FLUSH;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        FLUSH: begin
          // last pixel leaves the compute stage
          if (sts.can_adv) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/mtlf_dp.sv */
// meteor trail datapath: pixel store, read-modify-write stage, head and output register
// depends on mtlf_pkg and mtlf_pixel_if
module mtlf_dp #(
  parameter int STRIP_LENGTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mtlf_pkg::cfg_t                cfg,
  input  mtlf_pkg::cmd_t                cmd,
  input  logic [mtlf_pkg::MASK_W-1:0]   fade_mask_in,
  output mtlf_pkg::sts_t                sts,
  mtlf_pixel_if.source                  pixel
);
  import mtlf_pkg::*;

  localparam int AW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
  localparam int HW = $clog2(2 * STRIP_LENGTH);

  pix_t                    mem [STRIP_LENGTH];
  logic [STRIP_LENGTH-1:0] written;
  logic [STRIP_LENGTH-1:0] mask;
  logic [HW-1:0]           head;

  pix_t             rdata;
  logic             rvalid_bit;
  logic             s2_valid;
  logic [AW-1:0]    s2_idx;

  logic             adv;
  logic             wrap;
  logic             meteor;
  logic             last;
  logic [HW:0]      diff;
  logic [PCT_W-1:0] level;
  logic [PCT_W-1:0] faded;
  pix_t             cur;
  pix_t             upd;

  always_comb begin
    adv   = !pixel.valid || pixel.ready;
    cur   = rvalid_bit ? rdata : '0;
    faded = cur.intensity;
    if (mask[s2_idx]) begin
      faded = (cfg.fade_step > cur.intensity) ? '0 : cur.intensity - cfg.fade_step;
    end
    level  = (cfg.meteor_intensity > MAX_PCT) ? MAX_PCT : cfg.meteor_intensity;
    // distance behind the head, negative when the pixel is ahead of it
    diff   = {1'b0, head} - (HW + 1)'(s2_idx);
    meteor = !diff[HW] && (LEN_W'(diff[HW-1:0]) < cfg.meteor_length);
    wrap   = (head == HW'(2 * STRIP_LENGTH - 1));
    last   = (s2_idx == AW'(STRIP_LENGTH - 1));
    priority if (wrap) begin
      upd = '0;
    end else if (meteor) begin
      upd = '{lit: 1'b1, intensity: level};
    end else begin
      upd = '{lit: cur.lit, intensity: faded};
    end
    sts.can_adv  = adv;
    sts.s2_valid = s2_valid;
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[cmd.idx[AW-1:0]];
    end
    if (adv && s2_valid) begin
      mem[s2_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask <= fade_mask_in[STRIP_LENGTH-1:0];
    end
    if (adv) begin
      rvalid_bit <= written[cmd.idx[AW-1:0]];
      s2_idx     <= cmd.idx[AW-1:0];
    end
    if (adv && s2_valid) begin
      pixel.pixel_index <= IDX_W'(s2_idx);
      pixel.hue         <= upd.lit ? METEOR_HUE : '0;
      pixel.saturation  <= upd.lit ? METEOR_SAT : '0;
      pixel.intensity   <= upd.intensity;
      pixel.last_pixel  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid    <= 1'b0;
      pixel.valid <= 1'b0;
      written     <= '0;
      head        <= '0;
    end else if (adv) begin
      s2_valid    <= cmd.issue;
      pixel.valid <= s2_valid;
      if (s2_valid) begin
        written[s2_idx] <= 1'b1;
        if (last) begin
          head <= wrap ? '0 : head + 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/meteor_trail_led_frame.sv */
// meteor trail LED frame: top level with configuration registers and assertions
// depends on mtlf_pkg, mtlf_frame_if, mtlf_pixel_if, mtlf_ctrl and mtlf_dp
//
//   channel   dir   handshake      words per frame
//   frame     in    valid/ready    1 (fade mask)
//   pixel     out   valid/ready    STRIP_LENGTH, or 0 when disabled
//   cfg       in    cfg_we         register writes
//
// a frame sweeps the pixel store one pixel a cycle while the pixel side does not stall,
// read then read-modify-write
// the store sweep does one read and one write a cycle; pixel stalls hold the sweep
// a new frame is taken once the last pixel has left the compute stage
// rst is synchronous; the store reads as cleared through per-pixel valid bits
module meteor_trail_led_frame #(
  parameter int STRIP_LENGTH = 64
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [1:0]                   cfg_index,
  input logic [mtlf_pkg::PCT_W-1:0]   cfg_data,
  mtlf_frame_if.sink                  frame,
  mtlf_pixel_if.source                pixel
);
  import mtlf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b1;
      cfg.meteor_intensity <= RST_INTENSITY;
      cfg.fade_step        <= RST_FADE_STEP;
      cfg.meteor_length    <= RST_LENGTH;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLED:          cfg.enabled          <= cfg_data[0];
        REG_METEOR_INTENSITY: cfg.meteor_intensity <= cfg_data;
        REG_FADE_STEP:        cfg.fade_step        <= cfg_data;
        REG_METEOR_LENGTH:    cfg.meteor_length    <= cfg_data;
      endcase
    end
  end

  assign frame.ready = in_ready;

  mtlf_ctrl #(
    .STRIP_LENGTH(STRIP_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (in_ready),
    .enabled  (cfg.enabled),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtlf_dp #(
    .STRIP_LENGTH(STRIP_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .fade_mask_in (frame.fade_mask),
    .sts          (sts),
    .pixel        (pixel)
  );

  // no frame is taken while a pixel is still in the compute stage
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |-> !sts.s2_valid)
    else $error("frame accepted during a sweep");

  // an enabled frame starts a sweep and blocks the next one
  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && cfg.enabled) |=> !frame.ready)
    else $error("frame ready right after an enabled frame");

  // the read stage only issues while the sweep runs
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !frame.ready)
    else $error("store read issued while idle");

endmodule
